// ===== rtl/olex_pkg.sv =====
// Shared types, character constants and classification functions of the lexer.
package olex_pkg;

    typedef enum logic [2:0] {
        K_IDCHAR  = 3'd0,
        K_IDEND   = 3'd1,
        K_ADDOP   = 3'd2,
        K_MULOP   = 3'd3,
        K_LOGOP   = 3'd4,
        K_EOF     = 3'd5,
        K_ILLEGAL = 3'd6
    } t_kind;

    typedef enum logic [2:0] {
        M_IDLE    = 3'd0,
        M_IDENT   = 3'd1,
        M_SLASH   = 3'd2,
        M_COMMENT = 3'd3,
        M_AMP     = 3'd4,
        M_BAR     = 3'd5,
        M_HALT    = 3'd6
    } t_mode;

    localparam logic [7:0] CH_SP    = 8'h20;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_NL    = 8'h0A;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_STAR  = 8'h2A;
    localparam logic [7:0] CH_PCT   = 8'h25;
    localparam logic [7:0] CH_SLASH = 8'h2F;
    localparam logic [7:0] CH_AMP   = 8'h26;
    localparam logic [7:0] CH_BAR   = 8'h7C;

    localparam logic [15:0] LINE_FIRST = 16'd1;
    localparam logic [15:0] LINE_MAX   = 16'hFFFF;

    // Result queue: four entries, so two results per word fit behind up to two waiting results.
    localparam int QD  = 4;
    localparam int QAW = $clog2(QD);
    localparam int QCW = $clog2(QD + 1);

    typedef struct packed {
        t_kind       kind;
        logic [7:0]  value;
        logic [15:0] line;
        logic        last;
    } t_result;

    typedef struct packed {
        t_mode       mode;
        logic [15:0] line;
        logic [1:0]  count;
        t_result     res0;
        t_result     res1;
    } t_step;

    typedef struct packed {
        logic       emit;
        t_kind      kind;
        logic [7:0] value;
        t_mode      mode;
    } t_idle;

    function automatic logic is_letter(input logic [7:0] c);
        return (c >= 8'h61 && c <= 8'h7A) || (c >= 8'h41 && c <= 8'h5A);
    endfunction

    function automatic logic is_digit(input logic [7:0] c);
        return c >= 8'h30 && c <= 8'h39;
    endfunction

    // Handling of one byte or end mark between tokens.
    function automatic t_idle idle_step(input logic [7:0] c, input logic eoi);
        t_idle r;
        r.emit  = 1'b0;
        r.kind  = K_ILLEGAL;
        r.value = 8'h00;
        r.mode  = M_IDLE;
        if (eoi) begin
            r.emit = 1'b1;
            r.kind = K_EOF;
        end else if (c == CH_SP || c == CH_TAB || c == CH_NL) begin
            r.mode = M_IDLE;
        end else if (is_letter(c)) begin
            r.emit  = 1'b1;
            r.kind  = K_IDCHAR;
            r.value = c;
            r.mode  = M_IDENT;
        end else if (c == CH_PLUS || c == CH_MINUS) begin
            r.emit  = 1'b1;
            r.kind  = K_ADDOP;
            r.value = c;
        end else if (c == CH_STAR || c == CH_PCT) begin
            r.emit  = 1'b1;
            r.kind  = K_MULOP;
            r.value = c;
        end else if (c == CH_SLASH) begin
            r.mode = M_SLASH;
        end else if (c == CH_AMP) begin
            r.mode = M_AMP;
        end else if (c == CH_BAR) begin
            r.mode = M_BAR;
        end else begin
            r.emit  = 1'b1;
            r.kind  = K_ILLEGAL;
            r.value = c;
            r.mode  = M_HALT;
        end
        return r;
    endfunction

endpackage

// ===== rtl/operator_identifier_lexer_unit.sv =====
// Top level of the operator and identifier lexer with its stream ports.
//
// The lexer takes one source byte per input word, or an end-of-input mark flagged in tuser,
// and delivers tokens as output words: identifier characters one per word followed by an
// identifier-end word, add, multiply and logical operators, end of file, and an illegal-
// character word after which the block ignores all input until reset. Space, tab, newline and
// "//" comments produce nothing, and the saturating line number travels with every word.
// An accepted input word is held in an input register; the lexer logic then updates its mode
// and line count and writes zero, one or two results into a four-entry result queue once the
// queue has room for two, and the head of that queue is offered directly on the output port.
// A new input word is taken every cycle as long as the queue holds at most two results; a
// word that produces two results (an identifier or a lone slash closed by the next token)
// adds an extra output word, so the sustained input rate follows the output rate of one
// word per cycle while the receiver is ready. tlast marks the final result of one input word.
module operator_identifier_lexer_unit
    import olex_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [7:0]  i_s_axis_tdata,   // [7:0] ch
    input  logic        i_s_axis_tuser,   // [0] end_of_input
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [23:0] o_m_axis_tdata,   // [7:0] value, [23:8] line
    output logic [2:0]  o_m_axis_tuser,   // [2:0] kind
    output logic        o_m_axis_tlast
);

    logic           r_in_valid;
    logic [7:0]     r_ch;
    logic           r_eoi;
    t_mode          r_mode;
    t_mode          n_mode;
    logic [15:0]    r_line;
    logic [15:0]    n_line;
    t_step          step;
    logic           consume;
    logic           accept;
    logic           pop;
    logic [1:0]     push;
    logic [QCW-1:0] q_count;
    t_result        head;

    // The held word is processed only while the queue has room for two results.
    assign consume         = r_in_valid && (q_count <= QCW'(QD - 2));
    assign o_s_axis_tready = !r_in_valid || consume;
    assign accept          = i_s_axis_tvalid && o_s_axis_tready;
    assign push            = consume ? step.count : 2'd0;
    assign pop             = o_m_axis_tvalid && i_m_axis_tready;

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_ch  <= i_s_axis_tdata;
            r_eoi <= i_s_axis_tuser;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
            r_mode     <= M_IDLE;
            r_line     <= LINE_FIRST;
        end else begin
            r_in_valid <= accept || (r_in_valid && !consume);
            r_mode     <= n_mode;
            r_line     <= n_line;
        end
    end

    always_comb begin
        n_mode = r_mode;
        n_line = r_line;
        if (consume) begin
            n_mode = step.mode;
            n_line = step.line;
        end
    end

    olex_step u_step (
        .i_mode (r_mode),
        .i_line (r_line),
        .i_ch   (r_ch),
        .i_eoi  (r_eoi),
        .o_step (step)
    );

    olex_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_res0  (step.res0),
        .i_res1  (step.res1),
        .i_pop   (pop),
        .o_count (q_count),
        .o_head  (head)
    );

    assign o_m_axis_tvalid = (q_count != '0);
    assign o_m_axis_tdata  = {head.line, head.value};
    assign o_m_axis_tuser  = head.kind;
    assign o_m_axis_tlast  = head.last;

endmodule

// ===== rtl/olex_step.sv =====
// Next-state and result logic of the lexer for one registered input word.
module olex_step
    import olex_pkg::*;
(
    input  t_mode       i_mode,
    input  logic [15:0] i_line,
    input  logic [7:0]  i_ch,
    input  logic        i_eoi,
    output t_step       o_step
);

    t_idle       idle;
    logic [15:0] line_n;
    logic [7:0]  want;

    always_comb begin
        idle   = idle_step(i_ch, i_eoi);
        want   = (i_mode == M_AMP) ? CH_AMP : CH_BAR;
        line_n = i_line;
        if (i_mode != M_HALT && !i_eoi && i_ch == CH_NL && i_line != LINE_MAX) begin
            line_n = i_line + 16'd1;
        end

        o_step            = '0;
        o_step.mode       = i_mode;
        o_step.line       = line_n;
        o_step.res0.line  = line_n;
        o_step.res1.line  = line_n;
        o_step.res0.kind  = idle.kind;
        o_step.res0.value = idle.value;
        o_step.res1.kind  = idle.kind;
        o_step.res1.value = idle.value;

        unique case (i_mode)
            M_HALT: begin
                o_step.count = 2'd0;
            end
            M_IDENT: begin
                if (!i_eoi && (is_letter(i_ch) || is_digit(i_ch))) begin
                    o_step.res0.kind  = K_IDCHAR;
                    o_step.res0.value = i_ch;
                    o_step.count      = 2'd1;
                end else begin
                    o_step.res0.kind  = K_IDEND;
                    o_step.res0.value = 8'h00;
                    o_step.count      = {idle.emit, ~idle.emit};
                    o_step.mode       = idle.mode;
                end
            end
            M_SLASH: begin
                if (!i_eoi && i_ch == CH_SLASH) begin
                    o_step.count = 2'd0;
                    o_step.mode  = M_COMMENT;
                end else begin
                    o_step.res0.kind  = K_MULOP;
                    o_step.res0.value = CH_SLASH;
                    o_step.count      = {idle.emit, ~idle.emit};
                    o_step.mode       = idle.mode;
                end
            end
            M_COMMENT: begin
                if (i_eoi) begin
                    o_step.res0.kind  = K_EOF;
                    o_step.res0.value = 8'h00;
                    o_step.count      = 2'd1;
                    o_step.mode       = M_IDLE;
                end else if (i_ch == CH_NL) begin
                    o_step.count = 2'd0;
                    o_step.mode  = M_IDLE;
                end else begin
                    o_step.count = 2'd0;
                end
            end
            M_AMP, M_BAR: begin
                o_step.count = 2'd1;
                if (!i_eoi && i_ch == want) begin
                    o_step.res0.kind  = K_LOGOP;
                    o_step.res0.value = want;
                    o_step.mode       = M_IDLE;
                end else begin
                    o_step.res0.kind  = K_ILLEGAL;
                    o_step.res0.value = i_eoi ? 8'h00 : i_ch;
                    o_step.mode       = M_HALT;
                end
            end
            default: begin
                o_step.count = {1'b0, idle.emit};
                o_step.mode  = idle.mode;
            end
        endcase

        // The final result of the word carries the last flag.
        o_step.res0.last = (o_step.count == 2'd1);
        o_step.res1.last = 1'b1;
    end

endmodule

// ===== rtl/olex_fifo.sv =====
// Small result queue that takes up to two results per cycle and gives one.
module olex_fifo
    import olex_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic [1:0]       i_push,
    input  t_result          i_res0,
    input  t_result          i_res1,
    input  logic             i_pop,
    output logic [QCW-1:0]   o_count,
    output t_result          o_head
);

    t_result          r_q [QD];
    logic [QAW-1:0]   r_wr;
    logic [QAW-1:0]   r_rd;
    logic [QCW-1:0]   r_count;
    logic [QAW-1:0]   wr1;

    assign wr1     = r_wr + QAW'(1);
    assign o_count = r_count;
    assign o_head  = r_q[r_rd];

    always_ff @(posedge i_clk) begin
        if (i_push != 2'd0) begin
            r_q[r_wr] <= i_res0;
        end
        if (i_push == 2'd2) begin
            r_q[wr1] <= i_res1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            r_wr    <= r_wr + QAW'(i_push);
            r_rd    <= r_rd + QAW'(i_pop);
            r_count <= r_count + QCW'(i_push) - QCW'(i_pop);
        end
    end

endmodule

// ===== rtl/olex_checker.sv =====
// Port-level checker for the lexer and the bind that attaches it.
module olex_checker
    import olex_pkg::*;
(
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_m_axis_tvalid,
    input logic        i_m_axis_tready,
    input logic [23:0] o_m_axis_tdata,
    input logic [2:0]  o_m_axis_tuser
);

    // A word that is offered stays offered until it is taken.
    a_hold_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !i_m_axis_tready |=> o_m_axis_tvalid)
        else $error("output word withdrawn before it was taken");

    // Line numbers start at one and never wrap to zero.
    a_line_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid |-> o_m_axis_tdata[23:8] != 16'd0)
        else $error("line number of zero delivered");

    // Identifier end and end of file carry no character.
    a_value_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && (o_m_axis_tuser == K_IDEND || o_m_axis_tuser == K_EOF)
        |-> o_m_axis_tdata[7:0] == 8'h00)
        else $error("identifier end or end of file with a nonzero value");

    // Line numbers of successive words never go down.
    a_line_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rst_n && o_m_axis_tvalid && i_m_axis_tready ##1 o_m_axis_tvalid
        |-> o_m_axis_tdata[23:8] >= $past(o_m_axis_tdata[23:8]))
        else $error("line number went backward between words");

endmodule

bind operator_identifier_lexer_unit olex_checker u_olex_checker (.*);

// ===== tb/testbench.sv =====
// Self-checking testbench of the operator and identifier lexer with random stream idling.
`timescale 1ns / 100ps

module testbench;
    import olex_pkg::*;

    // Cycles without any accepted word after which the run is declared hung.
    localparam int WATCHDOG_LIMIT = 4000;
    // Cycles allowed after the last expected word.
    localparam int DRAIN_CYCLES   = 20;
    // Length of the one long output stall that backs the lexer up into its input.
    localparam int LONG_STALL     = 400;
    // Number of output words seen before that stall starts.
    localparam int STALL_AFTER    = 200;
    // Directed and random words together before the closing lines and the halt.
    localparam int RANDOM_WORDS   = 1320;
    // A short run of blank lines ahead of the closing tokens.
    localparam int NEWLINE_FLOOD  = 6;

    // One input word: a source byte or an end-of-input mark.
    typedef struct packed {
        logic [7:0] ch;
        logic       eoi;
    } src_word_t;

    // One token word as the lexer should deliver it.
    typedef struct packed {
        t_kind       kind;
        logic [7:0]  value;
        logic [15:0] line;
        logic        last;
    } token_t;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_s_axis_tvalid = 1'b0;
    logic        o_s_axis_tready;
    logic [7:0]  i_s_axis_tdata = 8'h00;   // [7:0] ch
    logic        i_s_axis_tuser = 1'b0;    // [0] end_of_input
    logic        o_m_axis_tvalid;
    logic        i_m_axis_tready = 1'b0;
    logic [23:0] o_m_axis_tdata;           // [7:0] value, [23:8] line
    logic [2:0]  o_m_axis_tuser;           // [2:0] kind
    logic        o_m_axis_tlast;

    // Words waiting to be offered, tokens still owed by the lexer, and the tokens
    // that the word just accepted produces.
    src_word_t src_words[$];
    token_t    tokens_due[$];
    token_t    step_tokens[$];

    // Our own copy of the lexer state.
    t_mode       scan_mode;
    logic [15:0] line_no;

    int mismatches     = 0;
    int words_taken    = 0;
    int words_sent     = 0;
    int results_seen   = 0;
    int total_words    = 0;
    int send_gap       = 0;
    int rx_wait        = 0;
    int idle_cycles    = 0;
    bit long_stall_done = 1'b0;
    src_word_t next_word;
    token_t    want_tok;

    operator_identifier_lexer_unit i_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tuser  (i_s_axis_tuser),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tuser  (o_m_axis_tuser),
        .o_m_axis_tlast  (o_m_axis_tlast)
    );

    always #2 i_clk = ~i_clk;

    // ------------------------------------------------------------------
    // Prediction of the lexer.
    // ------------------------------------------------------------------

    function automatic bit is_alpha(input logic [7:0] c);
        return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
    endfunction

    function automatic bit is_num(input logic [7:0] c);
        return c >= "0" && c <= "9";
    endfunction

    // Every token carries the line number as it stands after this word's newline.
    task automatic post_token(input t_kind k, input logic [7:0] v);
        step_tokens.push_back('{kind: k, value: v, line: line_no, last: 1'b0});
    endtask

    // A byte or end mark that arrives between tokens; it yields at most one token.
    task automatic between_tokens(input logic [7:0] c, input logic eoi);
        scan_mode = M_IDLE;
        if (eoi) begin
            post_token(K_EOF, 8'h00);
        end else if (c == CH_SP || c == CH_TAB || c == CH_NL) begin
            scan_mode = M_IDLE;
        end else if (is_alpha(c)) begin
            post_token(K_IDCHAR, c);
            scan_mode = M_IDENT;
        end else if (c == CH_PLUS || c == CH_MINUS) begin
            post_token(K_ADDOP, c);
        end else if (c == CH_STAR || c == CH_PCT) begin
            post_token(K_MULOP, c);
        end else if (c == CH_SLASH) begin
            scan_mode = M_SLASH;
        end else if (c == CH_AMP) begin
            scan_mode = M_AMP;
        end else if (c == CH_BAR) begin
            scan_mode = M_BAR;
        end else begin
            post_token(K_ILLEGAL, c);
            scan_mode = M_HALT;
        end
    endtask

    // Advances the state by one accepted word and queues the tokens it owes.
    task automatic lex_step(input logic [7:0] c, input logic eoi);
        logic [7:0] pair_ch;
        step_tokens.delete();
        if (scan_mode == M_HALT) begin
            return;
        end
        if (!eoi && c == CH_NL && line_no != LINE_MAX) begin
            line_no = line_no + 16'd1;
        end
        case (scan_mode)
            M_IDENT: begin
                if (!eoi && (is_alpha(c) || is_num(c))) begin
                    post_token(K_IDCHAR, c);
                end else begin
                    // The identifier closes, then the byte starts whatever follows.
                    post_token(K_IDEND, 8'h00);
                    between_tokens(c, eoi);
                end
            end
            M_SLASH: begin
                if (!eoi && c == CH_SLASH) begin
                    scan_mode = M_COMMENT;
                end else begin
                    post_token(K_MULOP, CH_SLASH);
                    between_tokens(c, eoi);
                end
            end
            M_COMMENT: begin
                if (eoi) begin
                    post_token(K_EOF, 8'h00);
                    scan_mode = M_IDLE;
                end else if (c == CH_NL) begin
                    scan_mode = M_IDLE;
                end
            end
            M_AMP, M_BAR: begin
                pair_ch = (scan_mode == M_AMP) ? CH_AMP : CH_BAR;
                if (!eoi && c == pair_ch) begin
                    post_token(K_LOGOP, pair_ch);
                    scan_mode = M_IDLE;
                end else begin
                    // A lone ampersand or bar reports the byte that broke the pair.
                    post_token(K_ILLEGAL, eoi ? 8'h00 : c);
                    scan_mode = M_HALT;
                end
            end
            default: begin
                between_tokens(c, eoi);
            end
        endcase
        if (step_tokens.size() != 0) begin
            step_tokens[step_tokens.size() - 1].last = 1'b1;
        end
        foreach (step_tokens[i]) begin
            tokens_due.push_back(step_tokens[i]);
        end
    endtask

    // ------------------------------------------------------------------
    // Checking.
    // ------------------------------------------------------------------

    task automatic report_mismatch(input string msg);
        $display("mismatch at %0t ns: %s", $time, msg);
        mismatches++;
    endtask

    task automatic check_field(input string what, input logic [15:0] got,
                               input logic [15:0] want);
        if (got !== want) begin
            report_mismatch($sformatf("word %0d %s got %0h expected %0h",
                                      results_seen, what, got, want));
        end
    endtask

    // ------------------------------------------------------------------
    // Idling pattern shared by both sides.
    // ------------------------------------------------------------------

    // Every third block of 150 words runs without gaps; elsewhere most gaps are
    // short and a few are long.
    function automatic int pick_gap(input int n);
        int r;
        if ((n / 150) % 3 == 1) begin
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 55) begin
            return 0;
        end else if (r < 85) begin
            return $urandom_range(1, 2);
        end else if (r < 97) begin
            return $urandom_range(3, 8);
        end
        return $urandom_range(20, 50);
    endfunction

    // ------------------------------------------------------------------
    // Stimulus builders.
    // ------------------------------------------------------------------

    task automatic put_ch(input logic [7:0] c);
        src_words.push_back('{ch: c, eoi: 1'b0});
    endtask

    // The byte under an end mark is ignored by the lexer, so it is random.
    task automatic put_eoi();
        src_words.push_back('{ch: 8'($urandom_range(0, 255)), eoi: 1'b1});
    endtask

    function automatic logic [7:0] rand_letter();
        if ($urandom_range(0, 1) == 0) begin
            return 8'("A" + $urandom_range(0, 25));
        end
        return 8'("a" + $urandom_range(0, 25));
    endfunction

    task automatic put_ident();
        int len;
        len = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 24) : $urandom_range(1, 6);
        put_ch(rand_letter());
        repeat (len - 1) begin
            if ($urandom_range(0, 2) == 0) begin
                put_ch(8'("0" + $urandom_range(0, 9)));
            end else begin
                put_ch(rand_letter());
            end
        end
    endtask

    // A line comment whose body takes any byte but newline, so that every bit of
    // the byte field toggles; now and then the end mark cuts it short.
    task automatic put_comment();
        logic [7:0] b;
        put_ch(CH_SLASH);
        put_ch(CH_SLASH);
        repeat ($urandom_range(0, 12)) begin
            b = 8'($urandom_range(0, 255));
            put_ch((b == CH_NL) ? 8'hFF : b);
        end
        if ($urandom_range(0, 7) == 0) begin
            put_eoi();
        end else begin
            put_ch(CH_NL);
        end
    endtask

    // One well-formed piece of source; concatenations of these never halt the lexer.
    task automatic put_random_token();
        int r;
        r = $urandom_range(0, 19);
        if (r < 5) begin
            put_ident();
        end else if (r < 7) begin
            repeat ($urandom_range(1, 3)) begin
                case ($urandom_range(0, 2))
                    0:       put_ch(CH_SP);
                    1:       put_ch(CH_TAB);
                    default: put_ch(CH_NL);
                endcase
            end
        end else if (r < 9) begin
            put_ch($urandom_range(0, 1) ? CH_PLUS : CH_MINUS);
        end else if (r < 11) begin
            put_ch($urandom_range(0, 1) ? CH_STAR : CH_PCT);
        end else if (r < 12) begin
            put_ch(CH_SLASH);
        end else if (r < 14) begin
            put_comment();
        end else if (r < 15) begin
            put_ch(CH_AMP);
            put_ch(CH_AMP);
        end else if (r < 16) begin
            put_ch(CH_BAR);
            put_ch(CH_BAR);
        end else if (r < 17) begin
            put_eoi();
        end else if (r < 18) begin
            // A broken sequence: an identifier or lone slash cut by the end mark.
            if ($urandom_range(0, 1) == 0) begin
                put_ident();
            end else begin
                put_ch(CH_SLASH);
            end
            put_eoi();
        end else begin
            put_ident();
            put_ch(CH_SP);
        end
    endtask

    // An illegal byte in idle mode: anything that starts no token and is not blank.
    function automatic logic [7:0] rand_stray_byte();
        logic [7:0] b;
        do begin
            b = 8'($urandom_range(0, 255));
        end while (is_alpha(b) || b == CH_SP || b == CH_TAB || b == CH_NL ||
                   b == CH_PLUS || b == CH_MINUS || b == CH_STAR || b == CH_PCT ||
                   b == CH_SLASH || b == CH_AMP || b == CH_BAR);
        return b;
    endfunction

    // ------------------------------------------------------------------
    // Driver: offers the queued words one by one, with random gaps between them.
    // A word stays on the bus until the lexer takes it.
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_s_axis_tvalid <= 1'b0;
        end else if (!i_s_axis_tvalid || o_s_axis_tready) begin
            if (send_gap > 0) begin
                send_gap--;
                i_s_axis_tvalid <= 1'b0;
            end else if (src_words.size() != 0) begin
                next_word = src_words.pop_front();
                i_s_axis_tdata  <= next_word.ch;
                i_s_axis_tuser  <= next_word.eoi;
                i_s_axis_tvalid <= 1'b1;
                send_gap = pick_gap(words_sent);
                words_sent++;
            end else begin
                i_s_axis_tvalid <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------
    // Monitor: predicts on every accepted input word, checks every accepted output
    // word against the oldest token owed, and drives the receiver's ready. The
    // receiver stalls at random and once holds off for a long stretch so that the
    // result queue fills and the lexer must drop its input ready.
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        int g;
        if (!i_rst_n) begin
            scan_mode = M_IDLE;
            line_no   = LINE_FIRST;
            i_m_axis_tready <= 1'b0;
        end else begin
            if (i_s_axis_tvalid && o_s_axis_tready) begin
                lex_step(i_s_axis_tdata, i_s_axis_tuser);
                words_taken++;
            end

            if (o_m_axis_tvalid && i_m_axis_tready) begin
                if (tokens_due.size() == 0) begin
                    report_mismatch($sformatf("word %0d unexpected, kind %0d value %0h",
                                              results_seen, o_m_axis_tuser,
                                              o_m_axis_tdata[7:0]));
                end else begin
                    want_tok = tokens_due.pop_front();
                    check_field("kind",  16'(o_m_axis_tuser),       16'(want_tok.kind));
                    check_field("value", 16'(o_m_axis_tdata[7:0]),  16'(want_tok.value));
                    check_field("line",  o_m_axis_tdata[23:8],      want_tok.line);
                    check_field("last",  16'(o_m_axis_tlast),       16'(want_tok.last));
                end
                results_seen++;
            end

            if (rx_wait > 0) begin
                rx_wait--;
                i_m_axis_tready <= 1'b0;
            end else if (!long_stall_done && results_seen >= STALL_AFTER) begin
                long_stall_done = 1'b1;
                rx_wait = LONG_STALL - 1;
                i_m_axis_tready <= 1'b0;
            end else begin
                g = pick_gap(results_seen);
                if (g == 0) begin
                    i_m_axis_tready <= 1'b1;
                end else begin
                    rx_wait = g - 1;
                    i_m_axis_tready <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Watchdog: a hung handshake on either side ends the run.
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        if ((i_s_axis_tvalid && o_s_axis_tready) || (o_m_axis_tvalid && i_m_axis_tready)) begin
            idle_cycles = 0;
        end else begin
            idle_cycles++;
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("watchdog: no word moved for %0d cycles", WATCHDOG_LIMIT);
                $display("*** FAILED ***");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------
    // Stimulus and end of run.
    // ------------------------------------------------------------------
    initial begin
        int variant;

        // Directed opening: extreme letters and digits in an identifier closed by an
        // operator, every operator, a lone slash closed by a blank, both logical
        // pairs, a comment holding the bytes 0x00 and 0xFF, an identifier cut by the
        // end mark, a repeated end mark, and a lone slash closed by a letter and by
        // the end mark, each of which yields two tokens from one word.
        put_ch("A"); put_ch("z"); put_ch("0"); put_ch("9");
        put_ch(CH_PLUS); put_ch(CH_MINUS); put_ch(CH_STAR); put_ch(CH_PCT);
        put_ch(CH_SLASH); put_ch(CH_SP);
        put_ch(CH_AMP); put_ch(CH_AMP); put_ch(CH_BAR); put_ch(CH_BAR);
        put_ch(CH_SLASH); put_ch(CH_SLASH); put_ch(8'h00); put_ch(8'hFF); put_ch(CH_NL);
        put_ch(CH_TAB); put_ch("q"); put_eoi(); put_eoi();
        put_ch(CH_SLASH); put_ch("b"); put_ch(CH_SLASH); put_eoi();

        // Random source text built from well-formed pieces.
        while (src_words.size() < RANDOM_WORDS) begin
            put_random_token();
        end

        // A few blank lines, then tokens that carry the line number.
        repeat (NEWLINE_FLOOD) put_ch(CH_NL);
        put_ch(CH_SP); put_ch("x"); put_ch(CH_PLUS); put_ch(CH_NL); put_ch("y");
        put_ch(CH_SP);

        // The run ends on one of the ways to halt the lexer, since only reset
        // brings it back.
        variant = $urandom_range(0, 4);
        case (variant)
            0: put_ch(8'hFF);
            1: put_ch(8'($urandom_range(8'h80, 8'hFE)));
            2: put_ch(rand_stray_byte());
            3: begin
                put_ch(CH_AMP);
                put_ch(($urandom_range(0, 3) == 0) ? CH_NL : rand_stray_byte());
            end
            default: begin
                put_ch(CH_BAR);
                put_eoi();
            end
        endcase

        // Once halted, the lexer must swallow everything without a token.
        put_ch(CH_NL); put_ch("a"); put_eoi(); put_ch(CH_PLUS); put_ch(8'h00);

        total_words = src_words.size();

        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (words_taken < total_words) @(negedge i_clk);
        while (tokens_due.size() != 0) @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);

        if (mismatches == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule
